[sv/fce_pkg.sv]
// ----------------------------------------------------------------------------
// fce_pkg
// Shared widths, link codes, command codes and the control/status bundles
// between the chain engine controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fce_pkg;

  // default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 4096;

  // field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 13;
  localparam int unsigned BLK_W  = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned LINK_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // link codes
  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;
  localparam logic [LINK_W-1:0] LINK_BAD  = 16'hFFFE;
  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_APP_TAIL,
    OP_APP_RUN,
    OP_FREE_START,
    OP_FREE_STEP,
    OP_LOAD,
    OP_READ_ISSUE,
    OP_READ_TAKE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic cnt_gt1;
    logic idx_in_table;
    logic walk_stop;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/fat_chain_engine_core.sv]
// Append writes the tail link, then the run entries; free walks the chain and
// clears each entry; load writes one entry and read returns one table link.
// Throughput: one command at a time; append and free move one table entry per
// cycle, bounded by the single write port of the link table.
// Reset clears the controller and output valid; table contents stay undefined.
// ----------------------------------------------------------------------------
// fat_chain_engine_core
// File allocation table chain engine: append runs, free chains, load and
// read single links in a table of 16-bit entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_engine_core
  import fce_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [CMD_W-1:0]        in_cmd_i,
  input  wire logic signed [IDX_W-1:0] in_chain_index_i,
  input  wire logic [BLK_W-1:0]        in_first_block_i,
  input  wire logic [CNT_W-1:0]        in_block_count_i,
  input  wire logic [LINK_W-1:0]       in_entry_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         out_status_o,
  output logic [BLK_W-1:0]             out_end_index_o,
  output logic                         out_head_started_o,
  output logic [LINK_W-1:0]            out_read_value_o
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  // command sequencer
  fce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (in_cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  // table and result datapath
  fce_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .ctl_i              (ctl),
    .sts_o              (sts),
    .in_chain_index_i   (in_chain_index_i),
    .in_first_block_i   (in_first_block_i),
    .in_block_count_i   (in_block_count_i),
    .in_entry_value_i   (in_entry_value_i),
    .out_status_o       (out_status_o),
    .out_end_index_o    (out_end_index_o),
    .out_head_started_o (out_head_started_o),
    .out_read_value_o   (out_read_value_o)
  );

endmodule

`default_nettype wire

[sv/fce_ctrl.sv]
// ----------------------------------------------------------------------------
// fce_ctrl
// Command sequencer: takes one beat at a time, steps the datapath through
// append, free, load or read, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fce_ctrl
  import fce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CMD_W-1:0] in_cmd_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dp_ctl_t               ctl_o,
  input  wire dp_sts_t          sts_i
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_APP_TAIL   = 4'd1;
  localparam logic [3:0] S_APP_RUN    = 4'd2;
  localparam logic [3:0] S_FREE_START = 4'd3;
  localparam logic [3:0] S_FREE_WALK  = 4'd4;
  localparam logic [3:0] S_LOAD       = 4'd5;
  localparam logic [3:0] S_READ_RD    = 4'd6;
  localparam logic [3:0] S_READ_WAIT  = 4'd7;
  localparam logic [3:0] S_DONE       = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    ctl_o.op       = OP_NONE;
    ctl_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_CAPTURE;
          unique case (in_cmd_i)
            CMD_APPEND: state_d = S_APP_TAIL;
            CMD_FREE:   state_d = S_FREE_START;
            CMD_LOAD:   state_d = S_LOAD;
            CMD_READ:   state_d = S_READ_RD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_APP_TAIL: begin
        ctl_o.op = OP_APP_TAIL;
        state_d  = S_APP_RUN;
      end
      S_APP_RUN: begin
        ctl_o.op = OP_APP_RUN;
        if (!sts_i.cnt_gt1) state_d = S_DONE;
      end
      S_FREE_START: begin
        ctl_o.op = OP_FREE_START;
        state_d  = sts_i.idx_in_table ? S_FREE_WALK : S_DONE;
      end
      S_FREE_WALK: begin
        ctl_o.op = OP_FREE_STEP;
        if (sts_i.walk_stop) state_d = S_DONE;
      end
      S_LOAD: begin
        ctl_o.op = OP_LOAD;
        state_d  = S_DONE;
      end
      S_READ_RD: begin
        ctl_o.op = OP_READ_ISSUE;
        state_d  = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        ctl_o.op = OP_READ_TAKE;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted beat did not start a command");

  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FREE_WALK |->
      $past(state_q) == S_FREE_START || $past(state_q) == S_FREE_WALK)
    else $error("free walk entered without a start");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APP_RUN && !sts_i.cnt_gt1 |=> state_q == S_DONE)
    else $error("append run did not finish on last link");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result load did not raise output valid");
`endif

endmodule

`default_nettype wire

[sv/fce_dp.sv]
// ----------------------------------------------------------------------------
// fce_dp
// Datapath: link table memory (one write, one registered read port), item
// registers, run and walk counters, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fce_dp
  import fce_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire dp_ctl_t                 ctl_i,
  output dp_sts_t                      sts_o,
  input  wire logic signed [IDX_W-1:0] in_chain_index_i,
  input  wire logic [BLK_W-1:0]        in_first_block_i,
  input  wire logic [CNT_W-1:0]        in_block_count_i,
  input  wire logic [LINK_W-1:0]       in_entry_value_i,
  output logic                         out_status_o,
  output logic [BLK_W-1:0]             out_end_index_o,
  output logic                         out_head_started_o,
  output logic [LINK_W-1:0]            out_read_value_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned VW = $clog2(TABLE_DEPTH + 1);
  localparam logic [LINK_W:0] DEPTH_V = (LINK_W+1)'(TABLE_DEPTH);

  // link table
  logic [LINK_W-1:0] link_mem [TABLE_DEPTH];

  logic signed [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [LINK_W-1:0]       value_q;
  logic [LINK_W-1:0]       cur_q;
  logic [VW-1:0]           visited_q;
  logic                    fwd_q;
  logic [LINK_W-1:0]       rdata_q;
  logic                    res_status_q;
  logic [BLK_W-1:0]        res_end_q;
  logic                    res_head_q;
  logic [LINK_W-1:0]       res_read_q;
  logic                    out_status_q;
  logic [BLK_W-1:0]        out_end_q;
  logic                    out_head_q;
  logic [LINK_W-1:0]       out_read_q;

  logic [LINK_W-1:0] idx16;
  logic              idx_in_table;
  logic              cur_in_table;
  logic              cnt_gt1;
  logic [LINK_W-1:0] link_v;
  logic [VW-1:0]     visited_inc;
  logic              walk_end;
  logic              walk_bad;
  logic              walk_stop;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // index and walk checks
  always_comb begin
    idx16        = {{(LINK_W-BLK_W){1'b0}}, idx_q[BLK_W-1:0]};
    idx_in_table = !idx_q[IDX_W-1] && ({1'b0, idx16} < DEPTH_V);
    cur_in_table = ({1'b0, cur_q} < DEPTH_V);
    cnt_gt1      = (cnt_q > CNT_W'(1));
    // entry just cleared and read back in the same cycle reads as free
    link_v       = fwd_q ? LINK_FREE : rdata_q;
    visited_inc  = visited_q + VW'(1);
    walk_end     = (link_v == LINK_END);
    walk_bad     = (link_v == LINK_FREE) || (link_v == LINK_BAD) ||
                   ({1'b0, link_v} >= DEPTH_V) ||
                   ((LINK_W+1)'(visited_inc) >= DEPTH_V);
    walk_stop    = walk_end || walk_bad;
  end

  assign sts_o.cnt_gt1      = cnt_gt1;
  assign sts_o.idx_in_table = idx_in_table;
  assign sts_o.walk_stop    = walk_stop;

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q[AW-1:0];
    mem_wdata = LINK_FREE;
    mem_re    = 1'b0;
    mem_raddr = idx16[AW-1:0];
    unique case (ctl_i.op)
      OP_APP_TAIL: begin
        mem_we    = idx_in_table;
        mem_waddr = idx16[AW-1:0];
        mem_wdata = cur_q;
      end
      OP_APP_RUN: begin
        mem_we    = cur_in_table;
        mem_wdata = cnt_gt1 ? (cur_q + LINK_W'(1)) : LINK_END;
      end
      OP_FREE_START: begin
        mem_re = 1'b1;
      end
      OP_FREE_STEP: begin
        mem_we    = 1'b1;
        mem_re    = !walk_stop;
        mem_raddr = link_v[AW-1:0];
      end
      OP_LOAD: begin
        mem_we    = idx_in_table;
        mem_waddr = idx16[AW-1:0];
        mem_wdata = value_q;
      end
      OP_READ_ISSUE: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // table write port
  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
  end

  // table read port
  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= link_mem[mem_raddr];
  end

  // item registers, counters and results
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_CAPTURE: begin
        idx_q        <= in_chain_index_i;
        cnt_q        <= in_block_count_i;
        value_q      <= in_entry_value_i;
        cur_q        <= {{(LINK_W-BLK_W){1'b0}}, in_first_block_i};
        res_status_q <= 1'b0;
        res_end_q    <= '0;
        res_head_q   <= 1'b0;
        res_read_q   <= '0;
      end
      OP_APP_TAIL: begin
        res_head_q <= idx_q[IDX_W-1];
      end
      OP_APP_RUN: begin
        if (cnt_gt1) begin
          cur_q <= cur_q + LINK_W'(1);
          cnt_q <= cnt_q - CNT_W'(1);
        end else begin
          res_end_q <= cur_q[BLK_W-1:0];
        end
      end
      OP_FREE_START: begin
        cur_q     <= idx16;
        visited_q <= '0;
        fwd_q     <= 1'b0;
        if (!idx_in_table) begin
          res_status_q <= 1'b1;
          res_end_q    <= idx_q[BLK_W-1:0];
        end
      end
      OP_FREE_STEP: begin
        if (walk_stop) begin
          res_status_q <= !walk_end;
          res_end_q    <= cur_q[BLK_W-1:0];
        end else begin
          cur_q     <= link_v;
          visited_q <= visited_inc;
          fwd_q     <= (link_v == cur_q);
        end
      end
      OP_READ_TAKE: begin
        res_read_q <= idx_in_table ? rdata_q : '0;
      end
      default: begin
        fwd_q <= fwd_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_end_q    <= res_end_q;
      out_head_q   <= res_head_q;
      out_read_q   <= res_read_q;
    end
  end

  assign out_status_o       = out_status_q;
  assign out_end_index_o    = out_end_q;
  assign out_head_started_o = out_head_q;
  assign out_read_value_o   = out_read_q;

endmodule

`default_nettype wire
